/* design/tsct_pkg.sv */
`timescale 1ns / 1ps
package tsct_pkg;

  localparam int COARSE_BITS  = 10;
  localparam int FINE_BITS    = 10;
  localparam int FRAC_BITS    = 16;
  localparam int TOTAL_BITS   = COARSE_BITS + FINE_BITS;
  localparam int IN_W         = 20;
  localparam int VAL_W        = FRAC_BITS + 2;
  localparam int TAN_INT_BITS = 7;
  localparam int TAN_W        = FRAC_BITS + TAN_INT_BITS + 1;
  localparam int ENT_W        = 2 * VAL_W;
  localparam int COARSE_SIZE  = 1 << COARSE_BITS;
  localparam int FINE_SIZE    = 1 << FINE_BITS;
  localparam int FILL_BITS    = (COARSE_BITS > FINE_BITS) ? COARSE_BITS : FINE_BITS;
  localparam int FILL_LEN     = 1 << FILL_BITS;
  localparam int PROD_W       = 2 * VAL_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int MAG_W        = VAL_W - 1;
  localparam int NUM_W        = MAG_W + FRAC_BITS + 1;
  localparam int CMP_W        = MAG_W + TAN_W;
  localparam int DIV_STEPS    = TAN_W;
  localparam int MQ_DEPTH     = 4;
  localparam int OQ_DEPTH     = 2;
  localparam int WORK_BITS    = 30;
  localparam int TAYLOR_TERMS = 12;
  localparam longint unsigned HALF_PI_WORK = 64'd1686629713;

  typedef enum logic [1:0] {
    TAN_OK    = 2'd0,
    TAN_SAT   = 2'd1,
    TAN_UNDEF = 2'd2
  } tan_flag_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sin_v;
    logic signed [VAL_W-1:0] cos_v;
  } sc_t;

  typedef logic [ENT_W-1:0] coarse_tab_t [COARSE_SIZE];
  typedef logic [ENT_W-1:0] fine_tab_t [FINE_SIZE];

  function automatic longint work_to_frac(input longint v);
    bit neg;
    longint unsigned mag;
    neg = v < 0;
    mag = neg ? longint'(-v) : longint'(v);
    mag = (mag + (64'd1 << (WORK_BITS - FRAC_BITS - 1))) >> (WORK_BITS - FRAC_BITS);
    if (mag > (64'd1 << FRAC_BITS)) mag = 64'd1 << FRAC_BITS;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint unsigned div_const(input longint unsigned a,
                                                input longint unsigned b);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ENT_W-1:0] rom_entry(input int unsigned k,
                                                 input int unsigned total);
    int unsigned rbits;
    int unsigned q;
    longint unsigned r, theta, t2, st, ct;
    longint sa, ca, s, c, so, co;
    logic [VAL_W-1:0] sv, cv;
    rbits = total - 2;
    q = (k >> rbits) & 3;
    r = longint'(k) & ((64'd1 << rbits) - 64'd1);
    theta = (HALF_PI_WORK * r) >> rbits;
    t2 = (theta * theta) >> WORK_BITS;
    st = theta;
    ct = 64'd1 << WORK_BITS;
    sa = 0;
    ca = 0;
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      sa = (n % 2 == 1) ? sa - longint'(st) : sa + longint'(st);
      ca = (n % 2 == 1) ? ca - longint'(ct) : ca + longint'(ct);
      st = div_const((st * t2) >> WORK_BITS, 64'((2 * n + 2) * (2 * n + 3)));
      ct = div_const((ct * t2) >> WORK_BITS, 64'((2 * n + 1) * (2 * n + 2)));
    end
    s = work_to_frac(sa);
    c = work_to_frac(ca);
    case (q)
      0: begin so = s;  co = c;  end
      1: begin so = c;  co = -s; end
      2: begin so = -s; co = -c; end
      default: begin so = -c; co = s; end
    endcase
    sv = so[VAL_W-1:0];
    cv = co[VAL_W-1:0];
    return {sv, cv};
  endfunction

  function automatic coarse_tab_t build_coarse();
    coarse_tab_t t;
    for (int i = 0; i < COARSE_SIZE; i++) t[i] = rom_entry(i, COARSE_BITS);
    return t;
  endfunction

  function automatic fine_tab_t build_fine();
    fine_tab_t t;
    for (int i = 0; i < FINE_SIZE; i++) t[i] = rom_entry(i, TOTAL_BITS);
    return t;
  endfunction

endpackage

/* design/two_table_sin_cos_tan_top.sv */
`timescale 1ns / 1ps
// Sine, cosine and tangent of a 20-bit phase (full turn = 2^20 steps) from a
// coarse and a fine sine/cosine table combined by angle addition. After reset the
// two tables are loaded in a pass during which full stays high. Then one phase
// is taken per clock while full is low; each result passes through the three-stage
// table/multiply front, the middle queue and the one-bit-per-stage tangent divider
// (24 stages). After loading, full rises only when the result queue backs up.
module two_table_sin_cos_tan_top import tsct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [IN_W-1:0]         in_phase_index,
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic signed [VAL_W-1:0] out_sine_value,
  output logic signed [VAL_W-1:0] out_cosine_value,
  output logic signed [TAN_W-1:0] out_tangent_value,
  output logic [1:0]              out_tangent_flag
);

  logic mq_full, mq_push, mq_pop, mq_empty;
  sc_t  mq_wdata, mq_rdata;

  tsct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_phase_index (in_phase_index),
    .mq_full        (mq_full),
    .mq_push        (mq_push),
    .mq_data        (mq_wdata)
  );

  tsct_midq u_midq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  tsct_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mq_data           (mq_rdata),
    .mq_empty          (mq_empty),
    .mq_pop            (mq_pop),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_sine_value    (out_sine_value),
    .out_cosine_value  (out_cosine_value),
    .out_tangent_value (out_tangent_value),
    .out_tangent_flag  (out_tangent_flag)
  );

endmodule

/* design/tsct_ram.sv */
`timescale 1ns / 1ps
module tsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata <= mem_r[raddr];
  end

endmodule

/* design/tsct_front.sv */
`timescale 1ns / 1ps
module tsct_front import tsct_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [IN_W-1:0] in_phase_index,
  input  logic            mq_full,
  output logic            mq_push,
  output sc_t             mq_data
);

  localparam coarse_tab_t COARSE_TAB = build_coarse();
  localparam fine_tab_t   FINE_TAB   = build_fine();

  logic [FILL_BITS:0] fill_cnt_r, fill_cnt_nxt;
  logic               busy, fadv, acc;
  logic               v1_r, v2_r, v3_r;
  logic [ENT_W-1:0]   coarse_q, fine_q;
  sc_t                cq, fq;
  logic signed [PROD_W-1:0] sccf_r, ccsf_r, cccf_r, scsf_r;
  sc_t                res_r, res_nxt;

  function automatic logic signed [VAL_W-1:0] rnd_unit(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag, r;
    logic [VAL_W-1:0] rv;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    r = (mag + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > (SUM_W'(1) << FRAC_BITS)) r = SUM_W'(1) << FRAC_BITS;
    rv = r[VAL_W-1:0];
    return v[SUM_W-1] ? -rv : rv;
  endfunction

  assign busy = fill_cnt_r != (FILL_BITS+1)'(FILL_LEN);
  assign fadv = !mq_full;
  assign in_full = busy || !fadv;
  assign acc = in_push && !in_full;
  assign fill_cnt_nxt = busy ? fill_cnt_r + 1'b1 : fill_cnt_r;

  tsct_ram #(.WIDTH(ENT_W), .DEPTH(COARSE_SIZE)) u_coarse (
    .clk   (clk),
    .we    (busy && (fill_cnt_r < (FILL_BITS+1)'(COARSE_SIZE))),
    .waddr (fill_cnt_r[COARSE_BITS-1:0]),
    .wdata (COARSE_TAB[fill_cnt_r[COARSE_BITS-1:0]]),
    .re    (fadv),
    .raddr (in_phase_index[TOTAL_BITS-1:FINE_BITS]),
    .rdata (coarse_q)
  );

  tsct_ram #(.WIDTH(ENT_W), .DEPTH(FINE_SIZE)) u_fine (
    .clk   (clk),
    .we    (busy && (fill_cnt_r < (FILL_BITS+1)'(FINE_SIZE))),
    .waddr (fill_cnt_r[FINE_BITS-1:0]),
    .wdata (FINE_TAB[fill_cnt_r[FINE_BITS-1:0]]),
    .re    (fadv),
    .raddr (in_phase_index[FINE_BITS-1:0]),
    .rdata (fine_q)
  );

  assign cq = sc_t'(coarse_q);
  assign fq = sc_t'(fine_q);

  always_comb begin
    res_nxt.sin_v = rnd_unit(SUM_W'(sccf_r) + SUM_W'(ccsf_r));
    res_nxt.cos_v = rnd_unit(SUM_W'(cccf_r) - SUM_W'(scsf_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      fill_cnt_r <= fill_cnt_nxt;
      if (fadv) begin
        v1_r <= acc;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fadv) begin
      sccf_r <= cq.sin_v * fq.cos_v;
      ccsf_r <= cq.cos_v * fq.sin_v;
      cccf_r <= cq.cos_v * fq.cos_v;
      scsf_r <= cq.sin_v * fq.sin_v;
      res_r  <= res_nxt;
    end
  end

  assign mq_push = v3_r && fadv;
  assign mq_data = res_r;

endmodule

/* design/tsct_midq.sv */
`timescale 1ns / 1ps
module tsct_midq import tsct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  sc_t  wdata,
  output logic full,
  input  logic pop,
  output sc_t  rdata,
  output logic empty
);

  localparam int PTR_W = $clog2(MQ_DEPTH);

  sc_t              data_r [MQ_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == (PTR_W+1)'(MQ_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = data_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) data_r[wp_r] <= wdata;
  end

endmodule

/* design/tsct_back.sv */
`timescale 1ns / 1ps
module tsct_back import tsct_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sc_t                     mq_data,
  input  logic                    mq_empty,
  output logic                    mq_pop,
  input  logic                    out_pop,
  output logic                    out_empty,
  output logic signed [VAL_W-1:0] out_sine_value,
  output logic signed [VAL_W-1:0] out_cosine_value,
  output logic signed [TAN_W-1:0] out_tangent_value,
  output logic [1:0]              out_tangent_flag
);

  typedef struct packed {
    logic             vld;
    sc_t              sc;
    logic             neg;
    logic             zero;
    logic             sat;
    logic [MAG_W-1:0] den;
    logic [NUM_W-1:0] rem;
    logic [TAN_W-1:0] q;
  } dv_t;

  typedef struct packed {
    sc_t              sc;
    logic [TAN_W-1:0] tan;
    tan_flag_t        flag;
  } res_t;

  localparam int OPTR_W = $clog2(OQ_DEPTH);

  dv_t              b0_r, b0_nxt, b1_nxt;
  dv_t              dv_r [DIV_STEPS+1];
  logic             badv, oq_full, oq_push, oq_pop;
  res_t             fin;
  res_t             oq_r [OQ_DEPTH];
  logic [OPTR_W-1:0] oq_wp_r, oq_rp_r;
  logic [OPTR_W:0]  oq_cnt_r, oq_cnt_nxt;
  logic [MAG_W-1:0] smag;
  logic [CMP_W-1:0] thr;

  function automatic dv_t div_step(input dv_t d, input int j);
    dv_t o;
    logic [CMP_W-1:0] sub;
    o = d;
    sub = CMP_W'(d.den) << j;
    if (CMP_W'(d.rem) >= sub) begin
      o.rem = d.rem - NUM_W'(sub);
      o.q[j] = 1'b1;
    end
    return o;
  endfunction

  assign oq_full = oq_cnt_r == (OPTR_W+1)'(OQ_DEPTH);
  assign badv    = !oq_full;
  assign mq_pop  = badv && !mq_empty;

  always_comb begin
    b0_nxt      = '0;
    b0_nxt.vld  = mq_pop;
    b0_nxt.sc   = mq_data;
    b0_nxt.neg  = mq_data.sin_v[VAL_W-1] != mq_data.cos_v[VAL_W-1];
    b0_nxt.zero = mq_data.cos_v == '0;
    b0_nxt.den  = mq_data.cos_v[VAL_W-1] ? MAG_W'(-mq_data.cos_v) : MAG_W'(mq_data.cos_v);
    smag        = mq_data.sin_v[VAL_W-1] ? MAG_W'(-mq_data.sin_v) : MAG_W'(mq_data.sin_v);
    b0_nxt.rem  = (NUM_W'(smag) << FRAC_BITS) + NUM_W'(b0_nxt.den >> 1);
  end

  always_comb begin
    b1_nxt = b0_r;
    thr = (CMP_W'(b0_r.den) << (TAN_W - 1)) + (b0_r.neg ? CMP_W'(b0_r.den) : '0);
    b1_nxt.sat = !b0_r.zero && (CMP_W'(b0_r.rem) >= thr);
  end

  always_comb begin
    fin.sc = dv_r[DIV_STEPS].sc;
    if (dv_r[DIV_STEPS].zero) begin
      fin.tan  = '0;
      fin.flag = TAN_UNDEF;
    end else if (dv_r[DIV_STEPS].sat) begin
      fin.tan  = dv_r[DIV_STEPS].neg ? {1'b1, {(TAN_W-1){1'b0}}} : {1'b0, {(TAN_W-1){1'b1}}};
      fin.flag = TAN_SAT;
    end else begin
      fin.tan  = dv_r[DIV_STEPS].neg ? -dv_r[DIV_STEPS].q : dv_r[DIV_STEPS].q;
      fin.flag = TAN_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r.vld <= 1'b0;
      for (int i = 0; i <= DIV_STEPS; i++) dv_r[i].vld <= 1'b0;
    end else if (badv) begin
      b0_r     <= b0_nxt;
      dv_r[0]  <= b1_nxt;
      for (int i = 1; i <= DIV_STEPS; i++) dv_r[i] <= div_step(dv_r[i-1], DIV_STEPS - i);
    end
  end

  assign oq_push = dv_r[DIV_STEPS].vld && badv;
  assign oq_pop  = out_pop && !out_empty;
  assign out_empty = oq_cnt_r == '0;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) oq_cnt_nxt = oq_cnt_r + 1'b1;
    if (!oq_push && oq_pop) oq_cnt_nxt = oq_cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) oq_wp_r <= oq_wp_r + 1'b1;
      if (oq_pop) oq_rp_r <= oq_rp_r + 1'b1;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) oq_r[oq_wp_r] <= fin;
  end

  assign out_sine_value    = oq_r[oq_rp_r].sc.sin_v;
  assign out_cosine_value  = oq_r[oq_rp_r].sc.cos_v;
  assign out_tangent_value = oq_r[oq_rp_r].tan;
  assign out_tangent_flag  = oq_r[oq_rp_r].flag;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push |-> !oq_full) else $error("result queue overflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OPTR_W+1)'(OQ_DEPTH)) else $error("result queue count out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    oq_full && !oq_pop |=> $stable(dv_r[DIV_STEPS].vld)) else $error("pipeline moved on stall");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    oq_push && dv_r[DIV_STEPS].zero |-> fin.tan == '0 && fin.flag == TAN_UNDEF)
    else $error("undefined tangent not zero");

endmodule
